### src/dqtt_pkg.sv
// ----------------------------------------------------------------------------
// dqtt_pkg: shared types and constants of the dual quadrature turn tracker
// Holds the request layout, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package dqtt_pkg;

  localparam int unsigned CountW  = 32;
  localparam int unsigned AngleW  = 18;
  localparam int unsigned TargetW = 18;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // request opcodes
  typedef enum logic {
    OP_PIN_SAMPLE = 1'b0,
    OP_START_TURN = 1'b1
  } opcode_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_GAIN_MAJOR  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_MINOR  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DONE_MARGIN = 2'd2;

  localparam logic [GainW-1:0] GAIN_RESET   = 16'd256;
  localparam logic [GainW-1:0] MARGIN_RESET = 16'd50;

  // one input request, last field (opcode) in the lowest bits
  typedef struct packed {
    logic signed [AngleW-1:0] turn_angle;
    logic                     pin_b_two;
    logic                     pin_a_two;
    logic                     pin_b_one;
    logic                     pin_a_one;
    opcode_t                  opcode;
  } in_item_t;

  // targets for a new turn
  typedef struct packed {
    logic [TargetW-1:0] mag_one;
    logic [TargetW-1:0] mag_two;
  } targets_t;

endpackage

### src/dqtt_quad_step.sv
// ----------------------------------------------------------------------------
// dqtt_quad_step: one 2x quadrature counter step
// Steps the count by one on a change of phase A; direction from A versus B.
// ----------------------------------------------------------------------------
module dqtt_quad_step (
  input  logic [dqtt_pkg::CountW-1:0] count_i,
  input  logic                        last_a_i,
  input  logic                        pin_a_i,
  input  logic                        pin_b_i,
  input  logic                        invert_i,   // reverse the counting sense
  output logic [dqtt_pkg::CountW-1:0] count_o
);

  logic step_up;

  assign step_up = (pin_a_i ^ pin_b_i) ^ invert_i;

  always_comb begin
    if (pin_a_i != last_a_i) begin
      count_o = step_up ? count_i + 32'd1 : count_i - 32'd1;
    end else begin
      count_o = count_i;
    end
  end

endmodule

### src/dqtt_turn_calc.sv
// ----------------------------------------------------------------------------
// dqtt_turn_calc: target magnitudes of a new turn
// Scales |angle| by the Q8.8 gains; gains swap for non-positive angles.
// ----------------------------------------------------------------------------
module dqtt_turn_calc (
  input  logic signed [dqtt_pkg::AngleW-1:0] turn_angle_i,
  input  logic        [dqtt_pkg::GainW-1:0]  gain_major_i,
  input  logic        [dqtt_pkg::GainW-1:0]  gain_minor_i,
  output dqtt_pkg::targets_t                 targets_o
);

  localparam int unsigned ProdW = dqtt_pkg::AngleW + dqtt_pkg::GainW;

  logic [dqtt_pkg::AngleW-1:0] mag;
  logic                        positive;
  logic [dqtt_pkg::GainW-1:0]  gain_one;
  logic [dqtt_pkg::GainW-1:0]  gain_two;
  logic [ProdW-1:0]            prod_one;
  logic [ProdW-1:0]            prod_two;

  // the most negative angle negates to itself, which is its magnitude
  assign mag      = turn_angle_i[dqtt_pkg::AngleW-1] ? 18'(-turn_angle_i)
                                                     : 18'(turn_angle_i);
  assign positive = !turn_angle_i[dqtt_pkg::AngleW-1] && (turn_angle_i != '0);
  assign gain_one = positive ? gain_major_i : gain_minor_i;
  assign gain_two = positive ? gain_minor_i : gain_major_i;

  assign prod_one = ProdW'(mag) * ProdW'(gain_one);
  assign prod_two = ProdW'(mag) * ProdW'(gain_two);

  // Q10.8 times Q8.8: drop 16 fraction bits; the result never exceeds 18 bits
  assign targets_o.mag_one = prod_one[ProdW-1:16];
  assign targets_o.mag_two = prod_two[ProdW-1:16];

endmodule

### src/dual_quadrature_turn_tracker_top.sv
// Path: a request passes the input register, then the result register that drives out_tvalid;
// a result-side stall can hold it in the input register.
// Throughput: one request per cycle while the result side keeps up; all state updates in one
// pass between the input and result registers, so pin samples stall only under back pressure.
// Back pressure: in_tready drops only while both registers hold requests and out_tready is low.
// Reset: synchronous, active low; counters, targets clear, last A levels go to one, gains 256.
// ----------------------------------------------------------------------------
// dual_quadrature_turn_tracker_top: two 2x quadrature counters and turn tracker
// Counts both encoders, starts turns with gain-scaled targets and reports done.
// ----------------------------------------------------------------------------
module dual_quadrature_turn_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // opcode
  input  logic [23:0] in_tdata,   // pin_a_one, pin_b_one, pin_a_two, pin_b_two,
                                  // turn_angle[17:0], pad
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // count_one[31:0], count_two[31:0], turn_done, pad
);

  // configuration registers
  logic [dqtt_pkg::GainW-1:0] gain_major_r;
  logic [dqtt_pkg::GainW-1:0] gain_minor_r;
  logic [dqtt_pkg::GainW-1:0] done_margin_r;

  // input register
  logic               s1_valid_r;
  dqtt_pkg::in_item_t s1_item_r;

  // tracker state
  logic [dqtt_pkg::CountW-1:0]  count_one_r, count_one_nxt, step_one;
  logic [dqtt_pkg::CountW-1:0]  count_two_r, count_two_nxt, step_two;
  logic [dqtt_pkg::TargetW-1:0] target_one_r, target_one_nxt;
  logic [dqtt_pkg::TargetW-1:0] target_two_r, target_two_nxt;
  logic                         last_a_one_r, last_a_one_nxt;
  logic                         last_a_two_r, last_a_two_nxt;
  logic                         active_r, active_nxt;

  // result register
  logic        out_valid_r;
  logic        out_done_r;
  logic        done_nxt;

  logic               s2_ready;
  logic               start;
  dqtt_pkg::targets_t new_targets;
  logic [dqtt_pkg::CountW-1:0] mag_one, mag_two;
  logic                        reach_one, reach_two, both_reached;

  // advance the pipeline whenever the result register is free or being taken
  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;

  // configuration writes land at once; issue them only while no request is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_major_r  <= dqtt_pkg::GAIN_RESET;
      gain_minor_r  <= dqtt_pkg::GAIN_RESET;
      done_margin_r <= dqtt_pkg::MARGIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        dqtt_pkg::REG_GAIN_MAJOR:  gain_major_r  <= cfg_wdata;
        dqtt_pkg::REG_GAIN_MINOR:  gain_minor_r  <= cfg_wdata;
        dqtt_pkg::REG_DONE_MARGIN: done_margin_r <= cfg_wdata;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= dqtt_pkg::in_item_t'({in_tdata[21:0], in_tuser});
    end
  end

  assign start = (s1_item_r.opcode == dqtt_pkg::OP_START_TURN);

  dqtt_quad_step u_step_one (
    .count_i  (count_one_r),
    .last_a_i (last_a_one_r),
    .pin_a_i  (s1_item_r.pin_a_one),
    .pin_b_i  (s1_item_r.pin_b_one),
    .invert_i (1'b0),
    .count_o  (step_one)
  );

  // encoder two counts the opposite way
  dqtt_quad_step u_step_two (
    .count_i  (count_two_r),
    .last_a_i (last_a_two_r),
    .pin_a_i  (s1_item_r.pin_a_two),
    .pin_b_i  (s1_item_r.pin_b_two),
    .invert_i (1'b1),
    .count_o  (step_two)
  );

  dqtt_turn_calc u_turn_calc (
    .turn_angle_i (s1_item_r.turn_angle),
    .gain_major_i (gain_major_r),
    .gain_minor_i (gain_minor_r),
    .targets_o    (new_targets)
  );

  // next state: a start turn clears counters and holds the last A levels,
  // a pin sample steps counters and records the new A levels
  always_comb begin
    if (start) begin
      count_one_nxt  = '0;
      count_two_nxt  = '0;
      target_one_nxt = new_targets.mag_one;
      target_two_nxt = new_targets.mag_two;
      last_a_one_nxt = last_a_one_r;
      last_a_two_nxt = last_a_two_r;
    end else begin
      count_one_nxt  = step_one;
      count_two_nxt  = step_two;
      target_one_nxt = target_one_r;
      target_two_nxt = target_two_r;
      last_a_one_nxt = s1_item_r.pin_a_one;
      last_a_two_nxt = s1_item_r.pin_a_two;
    end
  end

  // done check on the updated state: |count| + margin >= target,
  // the most negative count has magnitude 2^31
  assign mag_one = count_one_nxt[31] ? -count_one_nxt : count_one_nxt;
  assign mag_two = count_two_nxt[31] ? -count_two_nxt : count_two_nxt;
  assign reach_one = ({1'b0, mag_one} + 33'(done_margin_r)) >= 33'(target_one_nxt);
  assign reach_two = ({1'b0, mag_two} + 33'(done_margin_r)) >= 33'(target_two_nxt);
  assign both_reached = reach_one && reach_two;

  always_comb begin
    if (start || active_r) begin
      active_nxt = !both_reached;
      done_nxt   = both_reached;
    end else begin
      active_nxt = 1'b0;
      done_nxt   = 1'b1;
    end
  end

  // state and result registers advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_one_r  <= '0;
      count_two_r  <= '0;
      target_one_r <= '0;
      target_two_r <= '0;
      last_a_one_r <= 1'b1;
      last_a_two_r <= 1'b1;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        count_one_r  <= count_one_nxt;
        count_two_r  <= count_two_nxt;
        target_one_r <= target_one_nxt;
        target_two_r <= target_two_nxt;
        last_a_one_r <= last_a_one_nxt;
        last_a_two_r <= last_a_two_nxt;
        active_r     <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_done_r <= done_nxt;
    end
  end

  // the counters themselves are the reported counts
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_done_r, count_two_r, count_one_r};

  // a held result reports done exactly when no turn remains active
  a_done_matches_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_done_r == !active_r))
    else $error("turn_done disagrees with turn state");

  // a stalled request stays in the input register untouched
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("stalled request lost or changed");

  // a start turn reports both counters cleared
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready && start) |=> (count_one_r == '0 && count_two_r == '0))
    else $error("start turn did not clear counters");

endmodule

### tb/dual_quadrature_turn_tracker_top_test.sv
// ----------------------------------------------------------------------------
// dual_quadrature_turn_tracker_top_test: self-checking bench for the tracker
// Drives pin-sample and start-turn requests with random idling on both
// stream sides. A scoreboard class mirrors the counters, targets and
// registers, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module dual_quadrature_turn_tracker_top_test;

  // result layout, count_one in the lowest bits
  typedef struct packed {
    logic                        turn_done;
    logic [dqtt_pkg::CountW-1:0] count_two;
    logic [dqtt_pkg::CountW-1:0] count_one;
  } tally_t;

  // Mirror of the tracker: counters, targets, last A levels and registers.
  // note_request advances the mirror and queues the predicted tally;
  // check_result pops the oldest tally and compares it with the block.
  class encoder_tally;
    logic [dqtt_pkg::GainW-1:0]   gain_major;
    logic [dqtt_pkg::GainW-1:0]   gain_minor;
    logic [dqtt_pkg::GainW-1:0]   margin;
    logic [dqtt_pkg::CountW-1:0]  count_one;
    logic [dqtt_pkg::CountW-1:0]  count_two;
    logic [dqtt_pkg::TargetW-1:0] target_one;
    logic [dqtt_pkg::TargetW-1:0] target_two;
    logic                         last_a_one;
    logic                         last_a_two;
    logic                         turn_on;
    tally_t                       pending_tallies[$];
    int unsigned                  mismatches;
    int unsigned                  checked;
    int unsigned                  requests;
    int unsigned                  turns_started;
    int unsigned                  turns_ended;

    function new();
      gain_major = dqtt_pkg::GAIN_RESET;
      gain_minor = dqtt_pkg::GAIN_RESET;
      margin     = dqtt_pkg::MARGIN_RESET;
      count_one  = '0;
      count_two  = '0;
      target_one = '0;
      target_two = '0;
      last_a_one = 1'b1;
      last_a_two = 1'b1;
      turn_on    = 1'b0;
    endfunction

    function void set_register(logic [dqtt_pkg::CfgIdxW-1:0] idx,
                               logic [dqtt_pkg::GainW-1:0] val);
      case (idx)
        dqtt_pkg::REG_GAIN_MAJOR:  gain_major = val;
        dqtt_pkg::REG_GAIN_MINOR:  gain_minor = val;
        dqtt_pkg::REG_DONE_MARGIN: margin = val;
        default: ;
      endcase
    endfunction

    // floor(mag * gain / 2^16), clamped to the target width
    function logic [dqtt_pkg::TargetW-1:0] scaled_target(logic [dqtt_pkg::AngleW:0] mag,
                                                         logic [dqtt_pkg::GainW-1:0] gain);
      logic [63:0] prod;
      prod = (64'(mag) * 64'(gain)) >> 16;
      if (prod > 64'(262143)) prod = 64'(262143);
      return prod[dqtt_pkg::TargetW-1:0];
    endfunction

    // a margin above the target always counts as reached
    function bit reached(logic [dqtt_pkg::CountW-1:0] cnt,
                         logic [dqtt_pkg::TargetW-1:0] tgt);
      logic [dqtt_pkg::CountW-1:0] mag;
      longint                      need;
      mag  = cnt[dqtt_pkg::CountW-1] ? (32'd0 - cnt) : cnt;
      need = longint'(tgt) - longint'(margin);
      return longint'({32'd0, mag}) >= need;
    endfunction

    function void note_request(dqtt_pkg::in_item_t it);
      tally_t                      t;
      logic [dqtt_pkg::AngleW-1:0] raw;
      logic [dqtt_pkg::AngleW:0]   mag;
      requests++;
      if (it.opcode == dqtt_pkg::OP_PIN_SAMPLE) begin
        if (it.pin_a_one != last_a_one)
          count_one += (it.pin_a_one != it.pin_b_one) ? 32'd1 : 32'hFFFF_FFFF;
        if (it.pin_a_two != last_a_two)
          count_two += (it.pin_a_two != it.pin_b_two) ? 32'hFFFF_FFFF : 32'd1;
        last_a_one = it.pin_a_one;
        last_a_two = it.pin_a_two;
      end else begin
        raw = it.turn_angle;
        mag = raw[dqtt_pkg::AngleW-1] ? (19'h40000 - {1'b0, raw}) : {1'b0, raw};
        count_one = '0;
        count_two = '0;
        // positive angles use the major gain on encoder one, others swap
        if (!raw[dqtt_pkg::AngleW-1] && raw != '0) begin
          target_one = scaled_target(mag, gain_major);
          target_two = scaled_target(mag, gain_minor);
        end else begin
          target_one = scaled_target(mag, gain_minor);
          target_two = scaled_target(mag, gain_major);
        end
        turn_on = 1'b1;
        turns_started++;
      end
      if (!turn_on) begin
        t.turn_done = 1'b1;
      end else if (reached(count_one, target_one) && reached(count_two, target_two)) begin
        turn_on = 1'b0;
        t.turn_done = 1'b1;
        turns_ended++;
      end else begin
        t.turn_done = 1'b0;
      end
      t.count_one = count_one;
      t.count_two = count_two;
      pending_tallies.push_back(t);
    endfunction

    function void report(string what, longint want, longint got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [71:0] data);
      tally_t got;
      tally_t want;
      got = data[64:0];
      if (pending_tallies.size() == 0) begin
        report("unexpected result, count_one", 0, $signed(got.count_one));
        return;
      end
      want = pending_tallies.pop_front();
      checked++;
      if (got.count_one !== want.count_one)
        report("count_one", $signed(want.count_one), $signed(got.count_one));
      if (got.count_two !== want.count_two)
        report("count_two", $signed(want.count_two), $signed(got.count_two));
      if (got.turn_done !== want.turn_done)
        report("turn_done", want.turn_done, got.turn_done);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;   // opcode
  logic [23:0] in_tdata;   // pin_a_one, pin_b_one, pin_a_two, pin_b_two,
                           // turn_angle[17:0], pad
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // count_one[31:0], count_two[31:0], turn_done, pad

  encoder_tally tally;
  bit           eager;        // suppress idling on both sides
  logic [1:0]   phase_one;    // quadrature phase of each simulated encoder
  logic [1:0]   phase_two;
  int unsigned  settings_used;
  int           stall_left;

  dual_quadrature_turn_tracker_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, including long gaps and stalls.
  initial begin
    #2000000;
    $display("dual_quadrature_turn_tracker_top verification failed");
    $finish;
  end

  // Result side: mostly ready, short stalls now and then, a few long ones.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!eager && $urandom_range(0, 99) < 15) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 3);
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Sample accepted results at the rising edge and check them in order.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tally.check_result(out_tdata);
  end

  // Gap after a request: none most of the time, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (eager || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pin sample; the angle field carries random noise, which must be ignored.
  function automatic dqtt_pkg::in_item_t pin_sample(logic a1, logic b1, logic a2, logic b2);
    dqtt_pkg::in_item_t it;
    it.opcode     = dqtt_pkg::OP_PIN_SAMPLE;
    it.pin_a_one  = a1;
    it.pin_b_one  = b1;
    it.pin_a_two  = a2;
    it.pin_b_two  = b2;
    it.turn_angle = 18'($urandom());
    return it;
  endfunction

  // Start turn; the pin fields carry random noise, which must be ignored.
  function automatic dqtt_pkg::in_item_t start_turn(int angle);
    dqtt_pkg::in_item_t it;
    logic [3:0]         noise;
    noise         = 4'($urandom_range(0, 15));
    it.opcode     = dqtt_pkg::OP_START_TURN;
    it.pin_a_one  = noise[0];
    it.pin_b_one  = noise[1];
    it.pin_a_two  = noise[2];
    it.pin_b_two  = noise[3];
    it.turn_angle = 18'(angle);
    return it;
  endfunction

  // Turn angle: mostly a few tens of degrees so turns can finish,
  // some at the field extremes and some fully random.
  function automatic int pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return int'($signed(18'($urandom())));
    if (r < 20) begin
      case ($urandom_range(0, 4))
        0: return 92160;
        1: return -92160;
        2: return 131071;
        3: return -131072;
        default: return 0;
      endcase
    end
    return int'($urandom_range(0, 15360)) - 7680;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input dqtt_pkg::in_item_t it);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.opcode;
    in_tdata  <= {2'b00, it.turn_angle, it.pin_b_two, it.pin_a_two,
                  it.pin_b_one, it.pin_a_one};
    do @(posedge clk); while (!in_tready);
    tally.note_request(it);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop the request line so a held request is not taken twice.
  task automatic release_bus();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Wait for every predicted result, then let the pipeline drain.
  task automatic drain();
    release_bus();
    while (tally.pending_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers while the block is idle.
  task automatic apply_settings(input logic [15:0] major, input logic [15:0] minor,
                                input logic [15:0] margin);
    logic [dqtt_pkg::CfgIdxW-1:0] idx [3];
    logic [dqtt_pkg::GainW-1:0]   val [3];
    idx = '{dqtt_pkg::REG_GAIN_MAJOR, dqtt_pkg::REG_GAIN_MINOR, dqtt_pkg::REG_DONE_MARGIN};
    val = '{major, minor, margin};
    drain();
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      tally.set_register(idx[i], val[i]);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // One turn: start it, then rotate both encoders mostly one way, with
  // back steps, pauses and some glitched pin patterns mixed in.
  task automatic run_turn(input int angle, input int samples);
    logic [1:0] dir_one;
    logic [1:0] dir_two;
    logic [3:0] noise;
    int         r;
    eager   = ($urandom_range(0, 4) == 0);
    dir_one = $urandom_range(0, 1) ? 2'd1 : 2'd3;
    dir_two = $urandom_range(0, 1) ? 2'd1 : 2'd3;
    send_request(start_turn(angle));
    for (int i = 0; i < samples; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        noise = 4'($urandom_range(0, 15));
        send_request(pin_sample(noise[0], noise[1], noise[2], noise[3]));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) phase_one += dir_one;
        else if (r < 80) phase_one -= dir_one;
        r = $urandom_range(0, 99);
        if (r < 70) phase_two += dir_two;
        else if (r < 80) phase_two -= dir_two;
        // Gray code: A = p0 ^ p1, B = p1
        send_request(pin_sample(phase_one[0] ^ phase_one[1], phase_one[1],
                                phase_two[0] ^ phase_two[1], phase_two[1]));
      end
    end
  endtask

  initial begin
    logic [15:0] major;
    logic [15:0] minor;
    logic [15:0] margin;
    int unsigned phase_start;

    tally         = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tuser      = 1'b0;
    in_tdata      = '0;
    cfg_wr_en     = 1'b0;
    cfg_addr      = dqtt_pkg::REG_GAIN_MAJOR;
    cfg_wdata     = '0;
    eager         = 1'b0;
    phase_one     = 2'd0;
    phase_two     = 2'd0;
    settings_used = 1;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings (gain 1.0, margin 50).
    // Every pin pattern, with random angles riding along as noise.
    send_request(pin_sample(1'b0, 1'b0, 1'b0, 1'b0));
    send_request(pin_sample(1'b1, 1'b0, 1'b1, 1'b0));
    send_request(pin_sample(1'b0, 1'b1, 1'b0, 1'b1));
    send_request(pin_sample(1'b1, 1'b1, 1'b1, 1'b1));
    send_request(pin_sample(1'b0, 1'b0, 1'b1, 1'b1));
    send_request(pin_sample(1'b1, 1'b1, 1'b0, 1'b0));
    // Zero and tiny angles: targets fall inside the margin, done at once.
    send_request(start_turn(0));
    send_request(start_turn(1));
    send_request(start_turn(-1));
    send_request(start_turn(12800));
    // Full turn stays active; pins on the start request are ignored.
    send_request(start_turn(92160));
    send_request(pin_sample(1'b0, 1'b1, 1'b0, 1'b1));
    send_request(pin_sample(1'b1, 1'b1, 1'b1, 1'b1));
    // Restart while active, then the field extremes.
    send_request(start_turn(-92160));
    send_request(start_turn(131071));
    send_request(start_turn(-131072));
    send_request(pin_sample(1'b0, 1'b0, 1'b0, 1'b0));
    send_request(start_turn(-12801));
    send_request(pin_sample(1'b1, 1'b0, 1'b1, 1'b0));

    // Random part: register extremes first, then moderate random settings.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin major = 16'd0;     minor = 16'd0;     margin = 16'd0;     end
        1: begin major = 16'hFFFF;  minor = 16'hFFFF;  margin = 16'hFFFF;  end
        2: begin major = 16'hFFFF;  minor = 16'd0;     margin = 16'd0;     end
        3: begin major = 16'd0;     minor = 16'hFFFF;  margin = 16'd50;    end
        4: begin major = 16'd256;   minor = 16'd128;   margin = 16'd0;     end
        default: begin
          major  = $urandom_range(16, 1024);
          minor  = $urandom_range(16, 1024);
          margin = $urandom_range(0, 60);
        end
      endcase
      apply_settings(major, minor, margin);
      phase_start = tally.requests;
      while (tally.requests - phase_start < 175)
        run_turn(pick_angle(), $urandom_range(20, 90));
    end

    eager = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d requests over %0d register settings; checked %0d results.",
             tally.requests, settings_used, tally.checked);
    $display("Started %0d turns, %0d ended on reaching their targets; %0d mismatches.",
             tally.turns_started, tally.turns_ended, tally.mismatches);
    if (tally.mismatches == 0 && tally.pending_tallies.size() == 0) begin
      $display("dual_quadrature_turn_tracker_top verification clean");
    end else begin
      $display("dual_quadrature_turn_tracker_top verification failed");
    end
    $finish;
  end

endmodule
